/* rtl/core/ppunpk_pkg.sv */
// Shared types and constants for the packed raw pixel unpacker.
`default_nettype none

package ppunpk_pkg;

	localparam int unsigned PIXEL_COUNT_BITS_DEF = 27;
	localparam int unsigned TOTAL_W              = 27;
	localparam int unsigned CFG_DATA_W           = 27;
	localparam int unsigned CFG_INDEX_W          = 1;
	localparam int unsigned ACC_W                = 17;
	localparam int unsigned HELD_W               = 4;
	localparam int unsigned RAW10_W              = 10;
	localparam int unsigned PIXEL_W              = 12;

	localparam logic [HELD_W:0] BYTE_BITS  = 5'd8;
	localparam logic [HELD_W:0] RAW10_BITS = 5'd10;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_UNPACK_MODE = 1'b0,
		REG_PIXEL_TOTAL = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		MODE_RAW10 = 1'b0,
		MODE_RAW12 = 1'b1
	} unpack_mode_t;

	typedef enum logic [1:0] {
		PH_B0 = 2'd0,
		PH_B1 = 2'd1,
		PH_B2 = 2'd2
	} triple_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} in_item_t;

	typedef struct packed {
		logic               valid;
		in_item_t           item;
	} in_stage_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel_value;
		logic               last_pixel;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/ppunpk_in_stage.sv */
// Input register stage: holds one accepted byte until the datapath consumes it.
`default_nettype none

module ppunpk_in_stage
	import ppunpk_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_end,
	input  wire logic       advance,
	output in_stage_t       stage
);

	logic     valid_s1;
	in_item_t item_s1;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.data_byte <= data_byte;
			item_s1.frame_end <= frame_end;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

`default_nettype wire

/* rtl/core/ppunpk_datapath.sv */
// Configuration registers, unpack state and the per-byte unpack logic.
`default_nettype none

module ppunpk_datapath
	import ppunpk_pkg::*;
#(
	parameter int unsigned PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire in_stage_t              stage,
	input  wire logic                   out_free,
	output logic                        advance,
	output logic                        load,
	output result_t                     result
);

	localparam int unsigned CW = PIXEL_COUNT_BITS;

	unpack_mode_t        mode_q;
	logic [TOTAL_W-1:0]  pixel_total_q;
	logic [CW-1:0]       total;

	logic [ACC_W-1:0]    acc_q, acc_d, acc_ins;
	logic [HELD_W-1:0]   held_q, held_d, held_rem;
	logic [HELD_W:0]     held_sum;
	logic [CW-1:0]       cnt_q, cnt_d, cnt_inc;
	triple_phase_t       phase_q, phase_d;
	logic [7:0]          hbyte_q, hbyte_d;
	logic                room, emit;
	logic [PIXEL_W-1:0]  pix;

	// Fit the programmed total to the counter width
	generate
		if (CW > TOTAL_W) begin : g_total_ext
			assign total = {{(CW-TOTAL_W){1'b0}}, pixel_total_q};
		end else if (CW == TOTAL_W) begin : g_total_eq
			assign total = pixel_total_q;
		end else begin : g_total_trunc
			assign total = pixel_total_q[CW-1:0];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_RAW10;
			pixel_total_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_UNPACK_MODE: mode_q        <= unpack_mode_t'(cfg_data[0]);
				REG_PIXEL_TOTAL: pixel_total_q <= cfg_data[TOTAL_W-1:0];
				default:         ;
			endcase
		end
	end

	assign room     = cnt_q < total;
	assign cnt_inc  = cnt_q + 1'b1;
	assign acc_ins  = acc_q | ({{(ACC_W-8){1'b0}}, stage.item.data_byte} << held_q);
	assign held_sum = {1'b0, held_q} + BYTE_BITS;
	assign held_rem = held_sum[HELD_W-1:0] - RAW10_BITS[HELD_W-1:0];

	always_comb begin
		acc_d   = acc_q;
		held_d  = held_q;
		cnt_d   = cnt_q;
		phase_d = phase_q;
		hbyte_d = hbyte_q;
		emit    = 1'b0;
		pix     = '0;

		if (mode_q == MODE_RAW10) begin
			// Stack the byte above the held bits, drop out ten at a time
			if (room) begin
				acc_d  = acc_ins;
				held_d = held_sum[HELD_W-1:0];
				if (held_sum >= RAW10_BITS) begin
					pix    = {{(PIXEL_W-RAW10_W){1'b0}}, acc_ins[RAW10_W-1:0]};
					acc_d  = acc_ins >> RAW10_W;
					held_d = held_rem;
					emit   = 1'b1;
				end
			end
		end else begin
			case (phase_q)
				PH_B0: begin
					hbyte_d = stage.item.data_byte;
					phase_d = PH_B1;
				end
				PH_B1: begin
					if (room) begin
						pix  = {hbyte_q, stage.item.data_byte[7:4]};
						emit = 1'b1;
					end
					hbyte_d = stage.item.data_byte;
					phase_d = PH_B2;
				end
				default: begin
					if (room) begin
						pix  = {hbyte_q[3:0], stage.item.data_byte};
						emit = 1'b1;
					end
					phase_d = PH_B0;
				end
			endcase
		end

		if (emit) begin
			cnt_d = cnt_inc;
		end

		// Frame end: drop any partial bits or bytes still held
		if (stage.item.frame_end) begin
			acc_d   = '0;
			held_d  = '0;
			cnt_d   = '0;
			phase_d = PH_B0;
			hbyte_d = '0;
		end
	end

	assign advance = stage.valid && (!emit || out_free);
	assign load    = advance && emit;

	assign result.pixel_value = pix;
	assign result.last_pixel  = (cnt_inc == total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			held_q  <= '0;
			cnt_q   <= '0;
			phase_q <= PH_B0;
			hbyte_q <= '0;
		end else if (advance) begin
			acc_q   <= acc_d;
			held_q  <= held_d;
			cnt_q   <= cnt_d;
			phase_q <= phase_d;
			hbyte_q <= hbyte_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/ppunpk_out_stage.sv */
// Result register: holds one unpacked pixel until the consumer takes it.
`default_nettype none

module ppunpk_out_stage
	import ppunpk_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire result_t        result,
	output logic                out_free,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [PIXEL_W-1:0]  pixel_value,
	output logic                last_pixel
);

	logic    valid_s2;
	result_t result_s2;

	assign out_free = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign pixel_value = result_s2.pixel_value;
	assign last_pixel  = result_s2.last_pixel;

endmodule

`default_nettype wire

/* rtl/core/packed_pixel_unpacker_core.sv */
// Top level of the packed raw pixel unpacker (10-bit and 12-bit packing).
//
//  Port group   Kind         Signals
//  in           valid/ready  in_valid, in_ready, data_byte, frame_end
//  out          valid/ready  out_valid, out_ready, pixel_value, last_pixel
//  cfg          write only   cfg_wr_en, cfg_index, cfg_data
//
// One byte is taken per clock when the consumer keeps up; each byte yields at most one pixel.
// A pixel passes from its accepted byte through the input register,
// then the unpack logic, into the result register.
// A byte that yields a pixel waits in the input register while the result register is full.
// Reset clears configuration and all unpack state; no clearing pass is needed.
`default_nettype none

module packed_pixel_unpacker_core
	import ppunpk_pkg::*;
#(
	parameter int unsigned PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   frame_end,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [PIXEL_W-1:0]          pixel_value,
	output logic                        last_pixel,
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	in_stage_t stage;
	result_t   result;
	logic      advance, load, out_free;

	ppunpk_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.advance   (advance),
		.stage     (stage)
	);

	ppunpk_datapath #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stage     (stage),
		.out_free  (out_free),
		.advance   (advance),
		.load      (load),
		.result    (result)
	);

	ppunpk_out_stage u_out_stage (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.result      (result),
		.out_free    (out_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_value (pixel_value),
		.last_pixel  (last_pixel)
	);

endmodule

`default_nettype wire

/* rtl/core/ppunpk_checker.sv */
// Port-level checks for the packed raw pixel unpacker, bound to the top level.
`default_nettype none

module ppunpk_checker
	import ppunpk_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [PIXEL_W-1:0]     pixel_value,
	input wire logic                   last_pixel,
	input wire logic                   cfg_wr_en,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic raw12_q;
	logic zero_total_q;

	// Track the programmed mode and whether the frame size is zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw12_q      <= 1'b0;
			zero_total_q <= 1'b1;
		end else if (cfg_wr_en) begin
			if (cfg_reg_t'(cfg_index) == REG_UNPACK_MODE) begin
				raw12_q <= cfg_data[0];
			end
			if (cfg_reg_t'(cfg_index) == REG_PIXEL_TOTAL) begin
				zero_total_q <= (cfg_data == '0);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_value) && $stable(last_pixel))
		else $error("result changed while stalled");

	a_rose_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result transaction without a byte accepted two edges earlier");

	a_zero_total_silent: assert property (@(posedge clk) disable iff (!arst_n)
		zero_total_q |-> !out_valid)
		else $error("pixel given with a zero frame size");

	a_raw10_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !raw12_q |-> pixel_value[PIXEL_W-1:RAW10_W] == '0)
		else $error("10-bit pixel wider than ten bits");

endmodule

bind packed_pixel_unpacker_core ppunpk_checker u_ppunpk_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the packed raw pixel unpacker core.
`timescale 1ns / 100ps

module tb_top
	import ppunpk_pkg::*;
();

	localparam int unsigned CLK_HALF       = 6;
	localparam int unsigned RESET_CYCLES   = 12;
	localparam int unsigned RANDOM_BYTES   = 1300;
	localparam int unsigned PRESSURE_BYTES = 24;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned TOTAL_MAX      = 67108864;

	typedef enum logic {
		ROW_BYTE = 1'b0,
		ROW_CFG  = 1'b1
	} row_kind_t;

	typedef enum logic [1:0] {
		CHK_MODEL = 2'd0,
		CHK_NONE  = 2'd1,
		CHK_PIXEL = 2'd2
	} check_t;

	typedef struct packed {
		row_kind_t             kind;
		cfg_reg_t              reg_idx;
		logic [CFG_DATA_W-1:0] value;
		logic [7:0]            data;
		logic                  fend;
		check_t                chk;
		result_t               typed;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [7:0]             data_byte;
	logic                   frame_end;
	logic                   out_valid;
	logic                   out_ready;
	logic [PIXEL_W-1:0]     pixel_value;
	logic                   last_pixel;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// unpacker mirror: configuration and frame state
	unpack_mode_t         cur_mode;
	logic [TOTAL_W-1:0]   cur_total;
	logic [ACC_W-1:0]     acc_bits;
	logic [HELD_W:0]      acc_count;
	logic [TOTAL_W-1:0]   pix_count;
	triple_phase_t        tri_phase;
	logic [7:0]           tri_hold;

	result_t     expected_pixels[$];
	dir_row_t    dir_table[$];
	int unsigned mismatch_count;
	int unsigned idle_cycles;
	bit          hold_req;
	bit          gap_free;

	packed_pixel_unpacker_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_value(pixel_value),
		.last_pixel (last_pixel),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	task automatic clear_frame;
		acc_bits  = '0;
		acc_count = '0;
		pix_count = '0;
		tri_phase = PH_B0;
		tri_hold  = '0;
	endtask

	// Book a pixel at the back of the expected queue.
	task automatic book_pixel(input result_t r);
		expected_pixels = {expected_pixels, r};
	endtask

	task automatic append_row(input dir_row_t row);
		dir_table = {dir_table, row};
	endtask

	// Work out the pixel, if any, that one byte yields and advance the mirror.
	task automatic unpack_byte(input logic [7:0] d, input logic fe, output bit emit,
			output result_t r);
		bit                 room;
		logic [PIXEL_W-1:0] pix;
		room = pix_count < cur_total;
		emit = 1'b0;
		pix  = '0;
		r    = '0;
		if (cur_mode == MODE_RAW10) begin
			// once the count is reached the byte is not taken in
			if (room) begin
				acc_bits  = acc_bits | (ACC_W'(d) << acc_count[3:0]);
				acc_count = acc_count + BYTE_BITS;
				if (acc_count >= RAW10_BITS) begin
					pix       = {2'b00, acc_bits[RAW10_W-1:0]};
					acc_bits  = acc_bits >> RAW10_W;
					acc_count = acc_count - RAW10_BITS;
					emit      = 1'b1;
				end
			end
		end else begin
			case (tri_phase)
				PH_B0: begin
					tri_hold  = d;
					tri_phase = PH_B1;
				end
				PH_B1: begin
					if (room) begin
						pix  = {tri_hold, d[7:4]};
						emit = 1'b1;
					end
					tri_hold  = d;
					tri_phase = PH_B2;
				end
				default: begin
					if (room) begin
						pix  = {tri_hold[3:0], d};
						emit = 1'b1;
					end
					tri_phase = PH_B0;
				end
			endcase
		end
		if (emit) begin
			pix_count     = pix_count + 1'b1;
			r.pixel_value = pix;
			r.last_pixel  = (pix_count == cur_total);
		end
		if (fe)
			clear_frame();
	endtask

	task automatic add_cfg(input cfg_reg_t idx, input int unsigned v);
		dir_row_t row;
		row         = '0;
		row.kind    = ROW_CFG;
		row.reg_idx = idx;
		row.value   = v[CFG_DATA_W-1:0];
		append_row(row);
	endtask

	task automatic add_byte(input logic [7:0] d, input logic fe, input check_t chk,
			input logic [PIXEL_W-1:0] pix, input logic last);
		dir_row_t row;
		row                   = '0;
		row.kind              = ROW_BYTE;
		row.data              = d;
		row.fend              = fe;
		row.chk               = chk;
		row.typed.pixel_value = pix;
		row.typed.last_pixel  = last;
		append_row(row);
	endtask

	// Offer one byte, hold it until the transaction completes, then book its expected pixel as its check kind asks.
	task automatic send_byte(input logic [7:0] d, input logic fe, input check_t chk,
			input result_t typed);
		bit      emit;
		result_t r;
		@(negedge clk);
		in_valid  <= 1'b1;
		data_byte <= d;
		frame_end <= fe;
		do @(posedge clk); while (!in_ready);
		unpack_byte(d, fe, emit, r);
		case (chk)
			CHK_MODEL: begin
				if (emit)
					book_pixel(r);
			end
			CHK_PIXEL: book_pixel(typed);
			default: ;
		endcase
	endtask

	task automatic sender_gap;
		int unsigned r;
		int unsigned n;
		r = $urandom_range(0, 99);
		if (!gap_free && r >= 65) begin
			n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(15, 50);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Drop valid, drain every pending pixel and let the pipeline empty.
	task automatic settle_idle;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_UNPACK_MODE)
			cur_mode = unpack_mode_t'(v[0]);
		else
			cur_total = v[TOTAL_W-1:0];
	endtask

	// Receiver: random stalls, plus one long hold-off when the sender asks for it.
	initial begin
		int unsigned r;
		int unsigned n;
		bit          hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_ready <= 1'b1;
					n = $urandom_range(1, 30);
				end else if (r < 92) begin
					out_ready <= 1'b0;
					n = $urandom_range(1, 3);
				end else begin
					out_ready <= 1'b0;
					n = $urandom_range(10, 40);
				end
				// cut the stretch short once a hold-off is requested
				while (n > 1 && !(hold_req && !hold_done)) begin
					@(negedge clk);
					n--;
				end
			end
		end
	end

	// Compare each delivered pixel with the oldest booked one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected pixel: pixel_value %0h last_pixel %0b",
					pixel_value, last_pixel);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (pixel_value !== want.pixel_value) begin
					$error("pixel_value: expected %0h, got %0h", want.pixel_value,
						pixel_value);
					mismatch_count++;
				end
				if (last_pixel !== want.last_pixel) begin
					$error("last_pixel: expected %0b, got %0b", want.last_pixel,
						last_pixel);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int unsigned sent_bytes;
		int unsigned nframes;
		int unsigned len;
		int unsigned r;
		int unsigned total_pick;
		bit          broken;
		logic [7:0]  d;
		logic        fe;

		mismatch_count = 0;
		idle_cycles    = 0;
		hold_req       = 1'b0;
		gap_free       = 1'b0;
		cur_mode       = MODE_RAW10;
		cur_total      = '0;
		clear_frame();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		data_byte = '0;
		frame_end = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_UNPACK_MODE;
		cfg_data  = '0;

		// zero pixel total after reset: nothing comes out
		add_byte(8'hFF, 1'b0, CHK_NONE,  12'h000, 1'b0);
		add_byte(8'h00, 1'b1, CHK_NONE,  12'h000, 1'b0);
		add_cfg(REG_PIXEL_TOTAL, 2);
		add_byte(8'hFF, 1'b0, CHK_NONE,  12'h000, 1'b0);
		add_byte(8'hFF, 1'b0, CHK_PIXEL, 12'h3FF, 1'b0);
		add_byte(8'h00, 1'b0, CHK_PIXEL, 12'h03F, 1'b1);
		// count reached: byte is ignored, then frame end clears
		add_byte(8'hFF, 1'b1, CHK_NONE,  12'h000, 1'b0);
		add_cfg(REG_UNPACK_MODE, MODE_RAW12);
		add_cfg(REG_PIXEL_TOTAL, 3);
		add_byte(8'hAB, 1'b0, CHK_NONE,  12'h000, 1'b0);
		add_byte(8'hCD, 1'b0, CHK_PIXEL, 12'hABC, 1'b0);
		add_byte(8'hEF, 1'b0, CHK_PIXEL, 12'hDEF, 1'b0);
		add_byte(8'h00, 1'b0, CHK_NONE,  12'h000, 1'b0);
		// trailing pair at frame end still yields its first pixel
		add_byte(8'hFF, 1'b1, CHK_PIXEL, 12'h00F, 1'b1);
		add_byte(8'h12, 1'b0, CHK_NONE,  12'h000, 1'b0);
		add_byte(8'h34, 1'b0, CHK_MODEL, 12'h000, 1'b0);
		add_byte(8'h56, 1'b0, CHK_MODEL, 12'h000, 1'b0);
		// short frame ending on a lone first byte
		add_byte(8'h78, 1'b1, CHK_NONE,  12'h000, 1'b0);
		// mode switch mid-frame: each mode keeps its own state
		add_byte(8'h9A, 1'b0, CHK_NONE,  12'h000, 1'b0);
		add_cfg(REG_UNPACK_MODE, MODE_RAW10);
		add_byte(8'h01, 1'b0, CHK_NONE,  12'h000, 1'b0);
		add_cfg(REG_UNPACK_MODE, MODE_RAW12);
		add_byte(8'hBC, 1'b0, CHK_MODEL, 12'h000, 1'b0);
		add_byte(8'hDE, 1'b1, CHK_MODEL, 12'h000, 1'b0);
		add_cfg(REG_PIXEL_TOTAL, TOTAL_MAX);
		add_byte(8'hFF, 1'b0, CHK_NONE,  12'h000, 1'b0);
		add_byte(8'hF0, 1'b0, CHK_PIXEL, 12'hFFF, 1'b0);
		add_byte(8'h0F, 1'b0, CHK_MODEL, 12'h000, 1'b0);
		add_byte(8'h00, 1'b1, CHK_NONE,  12'h000, 1'b0);
		add_cfg(REG_UNPACK_MODE, MODE_RAW10);
		add_byte(8'h00, 1'b0, CHK_NONE,  12'h000, 1'b0);
		add_byte(8'hC0, 1'b1, CHK_MODEL, 12'h000, 1'b0);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_CFG) begin
				settle_idle();
				write_reg(dir_table[i].reg_idx, dir_table[i].value);
			end else begin
				send_byte(dir_table[i].data, dir_table[i].fend, dir_table[i].chk,
					dir_table[i].typed);
				sender_gap();
			end
		end

		// long hold-off on the receiver while bytes keep coming back to back
		settle_idle();
		write_reg(REG_UNPACK_MODE, MODE_RAW12);
		write_reg(REG_PIXEL_TOTAL, TOTAL_MAX);
		hold_req = 1'b1;
		for (int unsigned i = 0; i < PRESSURE_BYTES; i++) begin
			send_byte(8'($urandom_range(0, 255)), i == PRESSURE_BYTES - 1, CHK_MODEL, '0);
		end

		sent_bytes = 0;
		while (sent_bytes < RANDOM_BYTES) begin
			settle_idle();
			r = $urandom_range(0, 99);
			if (r < 40)
				total_pick = $urandom_range(1, 8);
			else if (r < 70)
				total_pick = $urandom_range(9, 64);
			else if (r < 80)
				total_pick = 0;
			else if (r < 90)
				total_pick = $urandom_range(65, TOTAL_MAX);
			else
				total_pick = TOTAL_MAX;
			r = $urandom_range(0, 99);
			if (r < 70 || r >= 85)
				write_reg(REG_UNPACK_MODE, $urandom_range(0, 1));
			if (r < 85)
				write_reg(REG_PIXEL_TOTAL, total_pick);
			gap_free = ($urandom_range(0, 3) == 0);
			nframes  = $urandom_range(1, 4);
			repeat (nframes) begin
				if (cur_total == 0 || cur_total > 64)
					len = $urandom_range(1, 40);
				else if (cur_mode == MODE_RAW12)
					len = (3 * cur_total + 1) / 2 + $urandom_range(0, 2);
				else
					len = (10 * cur_total + 7) / 8 + $urandom_range(0, 2);
				broken = ($urandom_range(0, 99) < 15);
				if (broken)
					len = $urandom_range(1, len);
				for (int unsigned i = 0; i < len; i++) begin
					r = $urandom_range(0, 19);
					d = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
					fe = (i == len - 1) && !(broken && $urandom_range(0, 1) == 1);
					send_byte(d, fe, CHK_MODEL, '0);
					sender_gap();
					sent_bytes++;
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/ppunpk_pkg.sv
rtl/core/ppunpk_in_stage.sv
rtl/core/ppunpk_datapath.sv
rtl/core/ppunpk_out_stage.sv
rtl/core/packed_pixel_unpacker_core.sv
rtl/core/ppunpk_checker.sv
tb/sv/tb_top.sv
